>>> src/dmrrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrrs_pkg
// shared codes, reset values and bundle types of the round-robin sender
// ----------------------------------------------------------------------------
package dmrrs_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_SET     = 3'd1;
  localparam logic [2:0] OP_REFRESH = 3'd2;
  localparam logic [2:0] OP_QUIESCE = 3'd3;
  localparam logic [2:0] OP_POLL    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_COUNT   = 2'd0;
  localparam logic [1:0] REG_LOW     = 2'd1;
  localparam logic [1:0] REG_HIGH    = 2'd2;
  localparam logic [1:0] REG_LENGTHS = 2'd3;

  // configuration reset values
  localparam logic [3:0]  COUNT_RST   = 4'd8;
  localparam logic [63:0] LOW_RST     = 64'd0;
  localparam logic [63:0] HIGH_RST    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] LENGTHS_RST = 32'h8888_8888;

  typedef struct packed {
    logic [3:0]  count;
    logic [63:0] low;
    logic [63:0] high;
    logic [31:0] lengths;
  } cfg_t;

  // classified command passed from front to back
  typedef struct packed {
    logic [2:0] op;
    logic [2:0] instrument;
    logic [2:0] pos;
    logic [7:0] value;
  } cmd_t;

  typedef struct packed {
    logic       sent;
    logic [2:0] instrument_sent;
    logic [7:0] byte_value;
    logic       last;
  } res_t;

endpackage

>>> src/dmrrs_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrrs channel interfaces
// valid/ready channels for input items, result items and register writes
// ----------------------------------------------------------------------------
interface dmrrs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [2:0] instrument;
  logic [2:0] byte_position;
  logic [7:0] value;

  modport source (output valid, op, instrument, byte_position, value, input ready);
  modport sink (input valid, op, instrument, byte_position, value, output ready);
endinterface

interface dmrrs_out_if;
  logic       valid;
  logic       ready;
  logic       sent;
  logic [2:0] instrument_sent;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, sent, instrument_sent, byte_value, last, input ready);
  modport sink (input valid, sent, instrument_sent, byte_value, last, output ready);
endinterface

interface dmrrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/dmrrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrrs_front
// classifies input items, drops ignored ones and clamps set values
// ----------------------------------------------------------------------------
module dmrrs_front #(
  parameter int INSTRUMENTS   = 8,
  parameter int MESSAGE_BYTES = 8
) (
  input  logic [2:0]          op,
  input  logic [2:0]          instrument,
  input  logic [2:0]          byte_position,
  input  logic [7:0]          value,
  input  dmrrs_pkg::cfg_t     cfg,
  output logic                keep,
  output dmrrs_pkg::cmd_t     cmd
);

  localparam logic [4:0] INST_LIM = 5'(INSTRUMENTS);
  localparam logic [4:0] BYTE_LIM = 5'(MESSAGE_BYTES);

  logic       inst_ok;
  logic       pos_ok;
  logic [7:0] lo;
  logic [7:0] hi;
  logic [7:0] clamped;

  assign inst_ok = {2'b00, instrument} < INST_LIM;
  assign pos_ok  = {2'b00, byte_position} < BYTE_LIM;

  // instrument field is three bits, so it always has a packed limit slot
  assign lo = cfg.low[{instrument, 3'b000} +: 8];
  assign hi = cfg.high[{instrument, 3'b000} +: 8];

  // when the limits cross, a value below low takes low and any other takes high
  always_comb begin
    if (value < lo) begin
      clamped = lo;
    end else if (value > hi) begin
      clamped = hi;
    end else begin
      clamped = value;
    end
  end

  always_comb begin
    cmd.op         = op;
    cmd.instrument = instrument;
    cmd.pos        = byte_position;
    cmd.value      = (op == dmrrs_pkg::OP_SET) ? clamped : value;
    case (op)
      dmrrs_pkg::OP_LOAD, dmrrs_pkg::OP_SET: begin
        keep = inst_ok && pos_ok;
      end
      dmrrs_pkg::OP_REFRESH, dmrrs_pkg::OP_QUIESCE: begin
        keep = inst_ok;
      end
      dmrrs_pkg::OP_POLL: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

>>> src/dmrrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrrs_queue
// small command queue decoupling the front from the back
// ----------------------------------------------------------------------------
module dmrrs_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dmrrs_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output dmrrs_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dmrrs_pkg::cmd_t   q_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/dmrrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrrs_back
// message store, dirty flags, round-robin scan and byte emission
// ----------------------------------------------------------------------------
module dmrrs_back #(
  parameter int INSTRUMENTS   = 8,
  parameter int MESSAGE_BYTES = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dmrrs_pkg::cfg_t cfg,
  input  logic            cmd_valid,
  input  dmrrs_pkg::cmd_t cmd,
  output logic            cmd_pop,
  output logic            res_valid,
  output dmrrs_pkg::res_t res,
  input  logic            res_ready
);

  localparam int DEPTH  = INSTRUMENTS * MESSAGE_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int INST_W = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
  localparam int NCNT_W = $clog2(INSTRUMENTS + 1);
  localparam int BPOS_W = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
  localparam int LEN_W  = $clog2(MESSAGE_BYTES + 1);
  localparam logic [4:0] INST_LIM = 5'(INSTRUMENTS);
  localparam logic [4:0] BYTE_LIM = 5'(MESSAGE_BYTES);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SET_CHK   = 3'd1;
  localparam logic [2:0] ST_SCAN      = 3'd2;
  localparam logic [2:0] ST_EMIT_RD   = 3'd3;
  localparam logic [2:0] ST_EMIT_PUSH = 3'd4;
  localparam logic [2:0] ST_NONE      = 3'd5;

  function automatic logic [ADDR_W-1:0] slot_addr(logic [INST_W-1:0] inst,
                                                  logic [BPOS_W-1:0] pos);
    return ADDR_W'(32'(inst) * 32'(MESSAGE_BYTES) + 32'(pos));
  endfunction

  // store with per-entry valid bits, an unwritten entry reads as zero
  logic [7:0]        mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [7:0]        rd_data_r;
  logic              rd_vld_r;
  logic [7:0]        rd_byte;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  logic [2:0]              state_r, state_nxt;
  logic [INSTRUMENTS-1:0]  dirty_r, dirty_nxt;
  logic [INST_W-1:0]       next_r, next_nxt;
  logic [INST_W-1:0]       cand_r, cand_nxt;
  logic [NCNT_W-1:0]       n_r, n_nxt;
  logic [NCNT_W-1:0]       left_r, left_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [BPOS_W-1:0]       b_r, b_nxt;
  logic [ADDR_W-1:0]       set_addr_r, set_addr_nxt;
  logic [7:0]              set_val_r, set_val_nxt;
  logic [INST_W-1:0]       set_inst_r, set_inst_nxt;

  logic                    out_valid_r;
  dmrrs_pkg::res_t         out_res_r;
  logic                    out_load;
  logic                    push;
  dmrrs_pkg::res_t         push_res;

  logic [INST_W-1:0]       cmd_inst;
  logic [ADDR_W-1:0]       cmd_addr;
  logic [4:0]              cnt5, n5;
  logic [NCNT_W-1:0]       n_eff;
  logic [INST_W-1:0]       start;
  logic [NCNT_W-1:0]       cand_inc;
  logic [INST_W-1:0]       cand_step;
  logic [3:0]              cand4;
  logic [3:0]              nib;
  logic [4:0]              len5;
  logic                    is_last;

  assign rd_byte  = rd_vld_r ? rd_data_r : 8'd0;
  assign cmd_inst = INST_W'(cmd.instrument);
  assign cmd_addr = slot_addr(cmd_inst, BPOS_W'(cmd.pos));

  // effective instrument count and scan start
  assign cnt5  = {1'b0, cfg.count};
  assign n5    = (cnt5 == 5'd0) ? 5'd1 : ((cnt5 > INST_LIM) ? INST_LIM : cnt5);
  assign n_eff = NCNT_W'(n5);
  assign start = (NCNT_W'(next_r) < n_eff) ? next_r : '0;

  assign cand_inc  = NCNT_W'(cand_r) + 1'b1;
  assign cand_step = (cand_inc == n_r) ? '0 : INST_W'(cand_inc);

  // message length of the candidate
  assign cand4 = 4'(cand_r);
  assign nib   = cfg.lengths[{cand4[2:0], 2'b00} +: 4];
  always_comb begin
    if (cand4 > 4'd7) begin
      len5 = BYTE_LIM;
    end else if (nib == 4'd0) begin
      len5 = 5'd1;
    end else if ({1'b0, nib} > BYTE_LIM) begin
      len5 = BYTE_LIM;
    end else begin
      len5 = {1'b0, nib};
    end
  end

  assign is_last  = (LEN_W'(b_r) + 1'b1) == len_r;
  assign out_load = !out_valid_r || res_ready;

  always_comb begin
    state_nxt    = state_r;
    dirty_nxt    = dirty_r;
    next_nxt     = next_r;
    cand_nxt     = cand_r;
    n_nxt        = n_r;
    left_nxt     = left_r;
    len_nxt      = len_r;
    b_nxt        = b_r;
    set_addr_nxt = set_addr_r;
    set_val_nxt  = set_val_r;
    set_inst_nxt = set_inst_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = '0;
    mem_raddr    = '0;
    mem_wdata    = 8'd0;
    cmd_pop      = 1'b0;
    push         = 1'b0;
    push_res     = '0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            dmrrs_pkg::OP_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = cmd_addr;
              mem_wdata = cmd.value;
            end
            dmrrs_pkg::OP_SET: begin
              mem_re       = 1'b1;
              mem_raddr    = cmd_addr;
              set_addr_nxt = cmd_addr;
              set_val_nxt  = cmd.value;
              set_inst_nxt = cmd_inst;
              state_nxt    = ST_SET_CHK;
            end
            dmrrs_pkg::OP_REFRESH: begin
              dirty_nxt[cmd_inst] = 1'b1;
            end
            dmrrs_pkg::OP_QUIESCE: begin
              dirty_nxt[cmd_inst] = 1'b0;
            end
            dmrrs_pkg::OP_POLL: begin
              n_nxt     = n_eff;
              left_nxt  = n_eff;
              cand_nxt  = start;
              state_nxt = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SET_CHK: begin
        // write and mark dirty only on a change
        if (rd_byte != set_val_r) begin
          mem_we                = 1'b1;
          mem_waddr             = set_addr_r;
          mem_wdata             = set_val_r;
          dirty_nxt[set_inst_r] = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (dirty_r[cand_r]) begin
          dirty_nxt[cand_r] = 1'b0;
          next_nxt          = cand_step;
          len_nxt           = LEN_W'(len5);
          b_nxt             = '0;
          state_nxt         = ST_EMIT_RD;
        end else if (left_r == NCNT_W'(1)) begin
          state_nxt = ST_NONE;
        end else begin
          cand_nxt = cand_step;
          left_nxt = left_r - 1'b1;
        end
      end
      ST_EMIT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = slot_addr(cand_r, b_r);
        state_nxt = ST_EMIT_PUSH;
      end
      ST_EMIT_PUSH: begin
        if (out_load) begin
          push                     = 1'b1;
          push_res.sent            = 1'b1;
          push_res.instrument_sent = 3'(cand_r);
          push_res.byte_value      = rd_byte;
          push_res.last            = is_last;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            b_nxt     = b_r + 1'b1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_NONE: begin
        if (out_load) begin
          push          = 1'b1;
          push_res.last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dirty_r     <= '0;
      next_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
      next_r  <= next_nxt;
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    n_r        <= n_nxt;
    left_r     <= left_nxt;
    len_r      <= len_nxt;
    b_r        <= b_nxt;
    set_addr_r <= set_addr_nxt;
    set_val_r  <= set_val_nxt;
    set_inst_r <= set_inst_nxt;
    if (push) begin
      out_res_r <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
      rd_vld_r  <= vld_r[mem_raddr];
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_res_r;

endmodule

>>> src/dirty_message_round_robin_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_message_round_robin_sender
// per-instrument byte messages with dirty flags, sent out round-robin on poll
// ----------------------------------------------------------------------------
// Each instrument owns a short byte message and a dirty flag. Load writes a
// byte as given, set clamps it to the instrument's limits and marks the
// instrument dirty when the stored byte changes, refresh and quiesce set and
// clear the flag. A poll scans from the next-instrument pointer for the first
// dirty instrument and sends its message, one result item per byte with last
// on the final one; with nothing dirty it gives a single idle item (sent low,
// last high). The input side takes an item per cycle while the queue has
// room. In the back, load, refresh and quiesce act as the command leaves the
// queue, and set is a read of the stored byte followed by the conditional
// write. A poll leaves the queue, checks the instruments one by one and then
// sends each message byte as a read of the single-port message store
// followed by a load of the output register, which a stalled result channel
// holds back. A two-entry command queue lets new items enter while a poll
// is still emitting. Register writes are taken every cycle; message store
// entries read as zero until first written.
// ----------------------------------------------------------------------------
module dirty_message_round_robin_sender #(
  parameter int INSTRUMENTS   = 8,
  parameter int MESSAGE_BYTES = 8,
  parameter int QUEUE_DEPTH   = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  dmrrs_in_if.sink          in_if,
  dmrrs_out_if.source       out_if,
  dmrrs_cfg_if.sink         cfg_if
);

  // configuration registers
  dmrrs_pkg::cfg_t cfg_r;

  // front to queue
  logic            keep;
  dmrrs_pkg::cmd_t front_cmd;
  logic            q_full;
  logic            q_push;

  // queue to back
  logic            q_head_valid;
  dmrrs_pkg::cmd_t q_head;
  logic            q_pop;

  // back to output channel
  logic            res_valid;
  dmrrs_pkg::res_t res;

  // register port never stalls
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count   <= dmrrs_pkg::COUNT_RST;
      cfg_r.low     <= dmrrs_pkg::LOW_RST;
      cfg_r.high    <= dmrrs_pkg::HIGH_RST;
      cfg_r.lengths <= dmrrs_pkg::LENGTHS_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        dmrrs_pkg::REG_COUNT:   cfg_r.count   <= cfg_if.data[3:0];
        dmrrs_pkg::REG_LOW:     cfg_r.low     <= cfg_if.data;
        dmrrs_pkg::REG_HIGH:    cfg_r.high    <= cfg_if.data;
        dmrrs_pkg::REG_LENGTHS: cfg_r.lengths <= cfg_if.data[31:0];
        default: begin
        end
      endcase
    end
  end

  // front: classify and clamp, ignored items are accepted and dropped
  dmrrs_front #(
    .INSTRUMENTS   (INSTRUMENTS),
    .MESSAGE_BYTES (MESSAGE_BYTES)
  ) u_front (
    .op            (in_if.op),
    .instrument    (in_if.instrument),
    .byte_position (in_if.byte_position),
    .value         (in_if.value),
    .cfg           (cfg_r),
    .keep          (keep),
    .cmd           (front_cmd)
  );

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full && keep;

  dmrrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // back: store, flags, scan and emission with its own output register
  dmrrs_back #(
    .INSTRUMENTS   (INSTRUMENTS),
    .MESSAGE_BYTES (MESSAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (q_head_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (out_if.ready)
  );

  assign out_if.valid           = res_valid;
  assign out_if.sent            = res.sent;
  assign out_if.instrument_sent = res.instrument_sent;
  assign out_if.byte_value      = res.byte_value;
  assign out_if.last            = res.last;

endmodule

>>> src/dmrrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrrs_checker
// port-level checks on the result channel of the round-robin sender
// ----------------------------------------------------------------------------
module dmrrs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_sent,
  input logic [2:0] out_instrument_sent,
  input logic [7:0] out_byte_value,
  input logic       out_last
);

  // a stalled item stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // a stalled item keeps its payload
  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sent) && $stable(out_instrument_sent)
      && $stable(out_byte_value) && $stable(out_last))
    else $error("result payload changed while stalled");

  // idle poll answer is a lone, zeroed final item
  a_idle_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sent |-> out_last && out_instrument_sent == 3'd0
      && out_byte_value == 8'd0)
    else $error("idle result malformed");

  // nothing offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind dirty_message_round_robin_sender dmrrs_checker u_dmrrs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_if.valid),
  .out_ready           (out_if.ready),
  .out_sent            (out_if.sent),
  .out_instrument_sent (out_if.instrument_sent),
  .out_byte_value      (out_if.byte_value),
  .out_last            (out_if.last)
);
